// File: rtl/core/mep_pkg.sv
// ---------------------------------------------------------------------------
// mep_pkg: shared types and constants for the Mandelbrot escape pixel core
// Field widths, register indexes, color thresholds and inter-module structs.
// ---------------------------------------------------------------------------
package mep_pkg;

   localparam int C_W         = 32;
   localparam int MAX_ITER_W  = 10;
   localparam int SCALE_W     = 9;
   localparam int SCALE_FRAC  = 8;
   localparam int COUNT_W     = 10;
   localparam int COUNT_BITS  = 10;
   localparam int COLOR_W     = 24;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DIGIT_W     = 17;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET = MAX_ITER_W'(200);
   localparam logic [SCALE_W-1:0]    SCALE_RESET    = SCALE_W'(77);
   localparam logic [MAX_ITER_W-1:0] MIN_ITER       = MAX_ITER_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Q8 = CSR_IDX_W'(1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'((1 << COUNT_BITS) - 1);
   localparam logic [COUNT_W-1:0] LVL_LOW   = COUNT_W'(20);
   localparam logic [COUNT_W-1:0] LVL_MID   = COUNT_W'(50);
   localparam logic [COUNT_W-1:0] LVL_HIGH  = COUNT_W'(100);

   localparam logic [COLOR_W-1:0] COLOR_MID  = 24'h0FE0FF;
   localparam logic [COLOR_W-1:0] COLOR_HIGH = 24'h37FFFD;
   localparam logic [COLOR_W-1:0] COLOR_TOP  = 24'hB7FFFF;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_TEST,
      BK_SCALE,
      BK_OUT
   } bk_state_type;

   typedef struct packed {
      logic [MAX_ITER_W-1:0] max_iter;
      logic [SCALE_W-1:0]    scale_q8;
   } mep_cfg_type;

   typedef struct packed {
      logic signed [C_W-1:0] c_real;
      logic signed [C_W-1:0] c_imag;
      logic                  trivial;
   } mep_job_type;

   typedef struct packed {
      logic        valid;
      mep_job_type job;
   } mep_head_type;

endpackage

// File: rtl/core/mep_if.sv
// ---------------------------------------------------------------------------
// mep_if: valid/ready channels of the Mandelbrot escape pixel core
// Request, response and register-write channels with source/sink modports.
// ---------------------------------------------------------------------------
interface mep_req_if;
   import mep_pkg::*;

   logic                  valid;
   logic                  ready;
   logic signed [C_W-1:0] c_real;
   logic signed [C_W-1:0] c_imag;

   modport source (output valid, output c_real, output c_imag, input ready);
   modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mep_rsp_if;
   import mep_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] escape_count;
   logic [COUNT_W-1:0] scaled_count;
   logic [COLOR_W-1:0] pixel_colour;

   modport source (output valid, output escape_count, output scaled_count,
                   output pixel_colour, input ready);
   modport sink   (input valid, input escape_count, input scaled_count,
                   input pixel_colour, output ready);
endinterface

interface mep_csr_if;
   import mep_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mep_front.sv
// ---------------------------------------------------------------------------
// mep_front: request intake and job queue
// Accepts points, flags jobs that need no iteration, queues them for the back.
// ---------------------------------------------------------------------------
module mep_front (
   input  logic                  clock,
   input  logic                  reset,
   input  mep_pkg::mep_cfg_type  cfg,
   mep_req_if.sink               req_chan,
   input  logic                  pop,
   output mep_pkg::mep_head_type head
);
   import mep_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   mep_job_type       ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;
   mep_job_type       job;

   assign req_chan.ready = (fill_ff != FILL_W'(QUEUE_DEPTH));
   assign push           = req_chan.valid & req_chan.ready;

   assign job.c_real  = req_chan.c_real;
   assign job.c_imag  = req_chan.c_imag;
   assign job.trivial = (cfg.max_iter < MIN_ITER);

   assign head.valid = (fill_ff != '0);
   assign head.job   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= job;
      end
   end

endmodule

// File: rtl/core/mep_mul.sv
// ---------------------------------------------------------------------------
// mep_mul: digit-serial signed multiplier
// One DIGIT_W-bit digit of b per cycle, most significant first (Horner form).
// ---------------------------------------------------------------------------
module mep_mul #(
   parameter  int ZW   = 33,
   localparam int NDIG = (ZW + mep_pkg::DIGIT_W - 1) / mep_pkg::DIGIT_W,
   localparam int PW   = ZW + NDIG * mep_pkg::DIGIT_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic signed [ZW-1:0] a,
   input  logic signed [ZW-1:0] b,
   output logic                 last,
   output logic signed [PW-1:0] prod
);
   import mep_pkg::*;

   localparam int BW = NDIG * DIGIT_W;
   localparam int CW = $clog2(NDIG + 1);

   logic signed [ZW-1:0]      a_ff, a_in;
   logic [BW-1:0]             b_ff, b_in;
   logic signed [PW-1:0]      acc_ff, acc_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic                      first_ff, first_in;
   logic [DIGIT_W-1:0]        digit;
   logic signed [DIGIT_W:0]   dsig;
   logic signed [ZW+DIGIT_W:0] partial;

   assign digit   = b_ff[BW-1 -: DIGIT_W];
   assign dsig    = $signed({first_ff & digit[DIGIT_W-1], digit});
   assign partial = a_ff * dsig;
   assign last    = (cnt_ff == CW'(1));
   assign prod    = acc_ff;

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      if (load) begin
         a_in     = a;
         b_in     = BW'(b);
         cnt_in   = CW'(NDIG);
         first_in = 1'b1;
      end else if (cnt_ff != '0) begin
         acc_in   = (first_ff ? PW'(0) : (acc_ff <<< DIGIT_W)) + PW'(partial);
         b_in     = b_ff << DIGIT_W;
         cnt_in   = cnt_ff - 1'b1;
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

// File: rtl/core/mep_back.sv
// ---------------------------------------------------------------------------
// mep_back: escape-time iteration engine and color stage
// Runs z = z*z + c on three digit-serial multipliers, then scales and colors.
// ---------------------------------------------------------------------------
module mep_back #(
   parameter int FRAC_BITS = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mep_pkg::mep_cfg_type  cfg,
   input  mep_pkg::mep_head_type head,
   output logic                  pop,
   mep_rsp_if.source             rsp_chan
);
   import mep_pkg::*;

   // |x|,|y| < 2 before escape; one step adds at most |c| and the cross term
   localparam int ZW   = ((FRAC_BITS + 3 > C_W - 1) ? FRAC_BITS + 3 : C_W - 1) + 2;
   localparam int NDIG = (ZW + DIGIT_W - 1) / DIGIT_W;
   localparam int PW   = ZW + NDIG * DIGIT_W;
   localparam int PRW  = COUNT_W + SCALE_W;
   localparam logic signed [PW:0] LIMIT =
      {{(PW - FRAC_BITS - 2){1'b0}}, 1'b1, {(FRAC_BITS + 2){1'b0}}};

   bk_state_type          state_ff, state_in;
   logic [MAX_ITER_W-1:0] n_ff, n_in;
   logic signed [C_W-1:0] cr_ff, cr_in;
   logic signed [C_W-1:0] ci_ff, ci_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [PRW-1:0]        prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    esc_ff, esc_in;
   logic [COUNT_W-1:0]    scl_ff, scl_in;
   logic [COLOR_W-1:0]    col_ff, col_in;

   logic                  mul_load, last_xx, last_yy, last_xy, mul_last;
   logic signed [ZW-1:0]  x_ld, y_ld;
   logic signed [PW-1:0]  p_xx, p_yy, p_xy;
   logic signed [PW-1:0]  x2, y2, cross_xy, nx_full, ny_full;
   logic signed [PW:0]    mag_sq;
   logic                  escape;
   logic [MAX_ITER_W:0]   n_nxt;
   logic [PRW-SCALE_FRAC-1:0] shifted;
   logic [COUNT_W-1:0]    scaled;
   logic [COLOR_W-1:0]    color;

   mep_mul #(.ZW(ZW)) u_mul_xx (
      .clock(clock), .reset(reset), .load(mul_load),
      .a(x_ld), .b(x_ld), .last(last_xx), .prod(p_xx)
   );

   mep_mul #(.ZW(ZW)) u_mul_yy (
      .clock(clock), .reset(reset), .load(mul_load),
      .a(y_ld), .b(y_ld), .last(last_yy), .prod(p_yy)
   );

   mep_mul #(.ZW(ZW)) u_mul_xy (
      .clock(clock), .reset(reset), .load(mul_load),
      .a(x_ld), .b(y_ld), .last(last_xy), .prod(p_xy)
   );

   assign mul_last = last_xx & last_yy & last_xy;

   assign x2       = p_xx >>> FRAC_BITS;
   assign y2       = p_yy >>> FRAC_BITS;
   assign cross_xy = p_xy >>> (FRAC_BITS - 1);
   assign mag_sq   = {x2[PW-1], x2} + {y2[PW-1], y2};
   assign escape   = (mag_sq >= LIMIT);
   assign nx_full  = x2 - y2 + PW'(cr_ff);
   assign ny_full  = cross_xy + PW'(ci_ff);
   assign n_nxt    = {1'b0, n_ff} + (MAX_ITER_W + 1)'(1);

   assign shifted = prod_ff[PRW-1:SCALE_FRAC];
   assign scaled  = (shifted > (PRW - SCALE_FRAC)'(COUNT_MAX)) ? COUNT_MAX
                                                             : shifted[COUNT_W-1:0];

   always_comb begin
      priority if (scaled <= LVL_LOW) begin
         color = COLOR_W'({scaled, 3'b000}) + COLOR_W'({scaled, 2'b00});
      end else if (scaled <= LVL_MID) begin
         color = COLOR_MID;
      end else if (scaled <= LVL_HIGH) begin
         color = COLOR_HIGH;
      end else begin
         color = COLOR_TOP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      esc_in       = esc_ff;
      scl_in       = scl_ff;
      col_in       = col_ff;
      pop          = 1'b0;
      mul_load     = 1'b0;
      x_ld         = ZW'(head.job.c_real);
      y_ld         = ZW'(head.job.c_imag);
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop   = 1'b1;
               cr_in = head.job.c_real;
               ci_in = head.job.c_imag;
               n_in  = MAX_ITER_W'(1);
               if (head.job.trivial) begin
                  count_in = '0;
                  state_in = BK_SCALE;
               end else begin
                  mul_load = 1'b1;
                  state_in = BK_MUL;
               end
            end
         end
         BK_MUL: begin
            if (mul_last) begin
               state_in = BK_TEST;
            end
         end
         BK_TEST: begin
            x_ld = nx_full[ZW-1:0];
            y_ld = ny_full[ZW-1:0];
            priority if (escape) begin
               count_in = n_ff;
               state_in = BK_SCALE;
            end else if (n_nxt >= {1'b0, cfg.max_iter}) begin
               count_in = '0;
               state_in = BK_SCALE;
            end else begin
               n_in     = n_nxt[MAX_ITER_W-1:0];
               mul_load = 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_SCALE: begin
            prod_in  = count_ff * cfg.scale_q8;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               esc_in       = count_ff;
               scl_in       = scaled;
               col_in       = color;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      count_ff <= count_in;
      prod_ff  <= prod_in;
      esc_ff   <= esc_in;
      scl_ff   <= scl_in;
      col_ff   <= col_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.escape_count = esc_ff;
   assign rsp_chan.scaled_count = scl_ff;
   assign rsp_chan.pixel_colour = col_ff;

endmodule

// File: rtl/core/mandelbrot_escape_pixel_core.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_pixel_core: escape-time pixel evaluator
// Register block, request queue and iteration engine of the pixel core.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one point c (c_real, c_imag, signed, FRAC_BITS fraction
//   bits). rsp_chan returns one result per request, in order: escape_count,
//   scaled_count and pixel_colour. csr_chan writes max_iter (index 0) and
//   scale_q8 (index 1); other indexes are dropped. Write registers only while
//   no request is in flight.
// Iteration:
//   Each iteration runs NDIG = ceil(W/17) multiplier digit steps, W =
//   max(FRAC_BITS+3, 31)+2, then an escape test. After accept, the engine
//   runs n iterations (n the escape count, or max_iter-1 without escape),
//   then its scale and output states. One request is processed at a time.
// Reset and stall:
//   Reset empties the two-entry request queue, idles the engine and loads
//   max_iter 200, scale_q8 77. A stalled response holds in the output
//   register; the engine then takes one more request and waits in its color
//   stage, and the queue keeps accepting until full.
// ---------------------------------------------------------------------------
module mandelbrot_escape_pixel_core #(
   parameter int FRAC_BITS = 28
) (
   input logic       clock,
   input logic       reset,
   mep_req_if.sink   req_chan,
   mep_rsp_if.source rsp_chan,
   mep_csr_if.sink   csr_chan
);
   import mep_pkg::*;

   mep_cfg_type  cfg_ff, cfg_in;
   mep_head_type head;
   logic         pop;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MAX_ITER: cfg_in.max_iter = csr_chan.data[MAX_ITER_W-1:0];
            CSR_SCALE_Q8: cfg_in.scale_q8 = csr_chan.data[SCALE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iter <= MAX_ITER_RESET;
         cfg_ff.scale_q8 <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mep_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_chan(req_chan), .pop(pop), .head(head)
   );

   mep_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .head(head), .pop(pop), .rsp_chan(rsp_chan)
   );

`ifndef SYNTHESIS
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");

   a_cfg_reset: assert property (@(posedge clock)
      $past(reset) |-> (cfg_ff.max_iter == MAX_ITER_RESET &&
                        cfg_ff.scale_q8 == SCALE_RESET))
      else $error("registers not at reset values after reset");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_chan.valid && !head.valid))
      else $error("queue or response not cleared by reset");
`endif

endmodule

// File: test/tb_mandelbrot_escape_pixel_core.sv
// ---------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel_core: self-checking bench for the pixel core
// Walks a directed table of points and register writes, then random phases
// under varied max_iter and scale settings, with random idles on both
// channels and one long response hold-off. Every response is compared field
// by field with an in-order queue of typed values or fixed-point predictions.
// ---------------------------------------------------------------------------
module tb_mandelbrot_escape_pixel_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mep_pkg::*;

   localparam int FRAC = 28;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = CSR_IDX_W'(3);

   typedef struct packed {
      logic [COUNT_W-1:0] escape_count;
      logic [COUNT_W-1:0] scaled_count;
      logic [COLOR_W-1:0] pixel_colour;
   } pixel_result_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [31:0]      val_a;
      logic [31:0]      val_b;
      pixel_result_type want;
   } directed_row_type;

   logic clock;
   logic reset;

   mep_req_if req_chan ();
   mep_rsp_if rsp_chan ();
   mep_csr_if csr_chan ();

   mandelbrot_escape_pixel_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [MAX_ITER_W-1:0] max_iter_cfg;
   logic [SCALE_W-1:0]    scale_cfg;

   pixel_result_type pending_pixels[$];
   int requests_sent;
   int pixels_checked;
   int mismatches;
   bit idle_on;
   bit long_hold_done;
   int stall_left;

   directed_row_type directed_rows [31] = '{
      '{ROW_TYPED,   32'h00000000, 32'h00000000, '{10'd0, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'h7FFFFFFF, 32'h7FFFFFFF, '{10'd1, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'h80000000, 32'h80000000, '{10'd1, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'h7FFFFFFF, 32'h80000000, '{10'd1, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'h20000000, 32'h00000000, '{10'd1, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'hE0000000, 32'h00000000, '{10'd1, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'h00000000, 32'h10000000, '{10'd0, 10'd0, 24'd0}},
      '{ROW_PREDICT, 32'hF4000000, 32'h01999999, '0},
      '{ROW_PREDICT, 32'h04100000, 32'h00000000, '0},
      '{ROW_PREDICT, 32'hFFFFFFFF, 32'h00000001, '0},
      '{ROW_WRITE,   32'(CSR_SCALE_Q8), 32'd256, '0},
      '{ROW_WRITE,   32'(CSR_MAX_ITER), 32'd1023, '0},
      '{ROW_PREDICT, 32'h04001500, 32'h00000000, '0},
      '{ROW_TYPED,   32'h7FFFFFFF, 32'h00000000, '{10'd1, 10'd1, 24'd12}},
      '{ROW_WRITE,   32'(CSR_SCALE_Q8), 32'd511, '0},
      '{ROW_PREDICT, 32'h04001500, 32'h00000000, '0},
      '{ROW_PREDICT, 32'h04003000, 32'h00000400, '0},
      '{ROW_WRITE,   32'(CSR_MAX_ITER), 32'h0000FC00, '0},
      '{ROW_TYPED,   32'h7FFFFFFF, 32'h7FFFFFFF, '{10'd0, 10'd0, 24'd0}},
      '{ROW_WRITE,   32'(CSR_MAX_ITER), 32'd1, '0},
      '{ROW_TYPED,   32'h20000000, 32'h00000000, '{10'd0, 10'd0, 24'd0}},
      '{ROW_WRITE,   32'(CSR_SPARE_A), 32'd5, '0},
      '{ROW_WRITE,   32'(CSR_SPARE_B), 32'h0000FFFF, '0},
      '{ROW_TYPED,   32'h7FFFFFFF, 32'h00000000, '{10'd0, 10'd0, 24'd0}},
      '{ROW_WRITE,   32'(CSR_MAX_ITER), 32'd2, '0},
      '{ROW_WRITE,   32'(CSR_SCALE_Q8), 32'd0, '0},
      '{ROW_TYPED,   32'h7FFFFFFF, 32'h00000000, '{10'd1, 10'd0, 24'd0}},
      '{ROW_TYPED,   32'h00000000, 32'h00000000, '{10'd0, 10'd0, 24'd0}},
      '{ROW_PREDICT, 32'h5A5A5A5A, 32'hA5A5A5A5, '0},
      '{ROW_WRITE,   32'(CSR_MAX_ITER), 32'd200, '0},
      '{ROW_WRITE,   32'(CSR_SCALE_Q8), 32'd77, '0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(10ms);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // signed product shifted right with floor rounding
   function automatic longint floor_mul(input longint a, input longint b, input int s);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] prod;
      wa = a;
      wb = b;
      prod = wa * wb;
      return longint'(prod >>> s);
   endfunction

   function automatic pixel_result_type predict_pixel(input logic signed [31:0] cr_in,
                                                      input logic signed [31:0] ci_in);
      pixel_result_type px;
      longint cr, ci, x, y, x2, y2, nx, ny, limit;
      int unsigned count, scaled;
      cr = cr_in;
      ci = ci_in;
      x = 0;
      y = 0;
      x2 = 0;
      y2 = 0;
      limit = longint'(4) <<< FRAC;
      count = 0;
      for (int unsigned n = 1; n < int'(max_iter_cfg); n++) begin
         nx = x2 - y2 + cr;
         ny = floor_mul(x, y, FRAC - 1) + ci;
         x = nx;
         y = ny;
         x2 = floor_mul(x, x, FRAC);
         y2 = floor_mul(y, y, FRAC);
         if (x2 + y2 >= limit) begin
            count = n;
            break;
         end
      end
      scaled = (count * int'(scale_cfg)) >> SCALE_FRAC;
      if (scaled > int'(COUNT_MAX))
         scaled = COUNT_MAX;
      px.escape_count = COUNT_W'(count);
      px.scaled_count = COUNT_W'(scaled);
      if (px.scaled_count <= LVL_LOW)
         px.pixel_colour = COLOR_W'(scaled) * COLOR_W'(12);
      else if (px.scaled_count <= LVL_MID)
         px.pixel_colour = COLOR_MID;
      else if (px.scaled_count <= LVL_HIGH)
         px.pixel_colour = COLOR_HIGH;
      else
         px.pixel_colour = COLOR_TOP;
      return px;
   endfunction

   function automatic void pick_point(input bit cusp_only, output logic [31:0] cr,
                                      output logic [31:0] ci);
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (cusp_only) begin
         cr = 32'h04000000 + $urandom_range(32'h1000, 32'h4000);
         ci = 32'h0;
      end else if (pick == 0) begin
         cr = $urandom;
         ci = $urandom;
      end else if (pick == 1) begin
         cr = 32'h04000000 + $urandom_range(0, 32'h40000);
         ci = $urandom_range(0, 32'h80000) - 32'h40000;
      end else begin
         cr = 32'hE0000000 + $urandom_range(0, 32'h28000000);
         ci = $urandom_range(0, 32'h28000000) - 32'h14000000;
      end
   endfunction

   task automatic wait_drained();
      while (pixels_checked != requests_sent)
         @(posedge clock);
   endtask

   task automatic send_point(input logic [31:0] cr, input logic [31:0] ci,
                             input bit typed, input pixel_result_type typed_px);
      int gap;
      csr_chan.valid <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.c_real <= cr;
      req_chan.c_imag <= ci;
      do @(posedge clock); while (!req_chan.ready);
      pending_pixels.push_back(typed ? typed_px : predict_pixel(cr, ci));
      requests_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      req_chan.valid <= 1'b0;
      wait_drained();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == CSR_MAX_ITER)
         max_iter_cfg = value[MAX_ITER_W-1:0];
      else if (idx == CSR_SCALE_Q8)
         scale_cfg = value[SCALE_W-1:0];
   endtask

   task automatic run_phase(input int unsigned mi, input int unsigned sc, input int items,
                            input bit cusp_only);
      logic [31:0] cr, ci;
      write_register(CSR_MAX_ITER, {6'($urandom), MAX_ITER_W'(mi)});
      write_register(CSR_SCALE_Q8, {7'($urandom), SCALE_W'(sc)});
      for (int i = 0; i < items; i++) begin
         pick_point(cusp_only, cr, ci);
         send_point(cr, ci, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("response with no request pending");
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_chan.escape_count !== want.escape_count)
                  report_mismatch($sformatf("escape_count %0d, want %0d",
                                            rsp_chan.escape_count, want.escape_count));
               if (rsp_chan.scaled_count !== want.scaled_count)
                  report_mismatch($sformatf("scaled_count %0d, want %0d",
                                            rsp_chan.scaled_count, want.scaled_count));
               if (rsp_chan.pixel_colour !== want.pixel_colour)
                  report_mismatch($sformatf("pixel_colour %06h, want %06h",
                                            rsp_chan.pixel_colour, want.pixel_colour));
            end
            pixels_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!long_hold_done && pixels_checked == 30) begin
            long_hold_done = 1'b1;
            stall_left = 299;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.c_real <= '0;
      req_chan.c_imag <= '0;
      csr_chan.valid  <= 1'b0;
      csr_chan.index  <= '0;
      csr_chan.data   <= '0;
      max_iter_cfg = MAX_ITER_RESET;
      scale_cfg = SCALE_RESET;
      requests_sent = 0;
      pixels_checked = 0;
      mismatches = 0;
      long_hold_done = 1'b0;
      stall_left = 0;
      idle_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_WRITE: begin
               write_register(directed_rows[r].val_a[CSR_IDX_W-1:0],
                              directed_rows[r].val_b[CSR_DATA_W-1:0]);
            end
            ROW_TYPED: begin
               send_point(directed_rows[r].val_a, directed_rows[r].val_b, 1'b1,
                          directed_rows[r].want);
            end
            default: begin
               send_point(directed_rows[r].val_a, directed_rows[r].val_b, 1'b0, '0);
            end
         endcase
      end

      run_phase(24, 77, 80, 1'b0);
      for (int p = 0; p < 6; p++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         run_phase($urandom_range(2, 300), $urandom_range(0, 511), 70, 1'b0);
      end
      idle_on = 1'b1;
      run_phase(1023, 511, 8, 1'b1);
      run_phase(2, 256, 40, 1'b0);
      idle_on = 1'b0;
      run_phase(200, 77, 60, 1'b0);

      req_chan.valid <= 1'b0;
      csr_chan.valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (pending_pixels.size() != 0)
         report_mismatch("requests left without a response");
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
